// ----- design/urs_pkg.sv -----
// Shared types and codes for the unaligned read splitter.
// Holds the state and result records and the phase and action codes; no dependencies.
package urs_pkg;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SMALL  = 3'd1;
    localparam logic [2:0] PH_HEAD   = 3'd2;
    localparam logic [2:0] PH_DIRECT = 3'd3;
    localparam logic [2:0] PH_TAIL   = 3'd4;

    localparam logic [2:0] ACT_RD_BOUNCE = 3'd0;
    localparam logic [2:0] ACT_RD_DIRECT = 3'd1;
    localparam logic [2:0] ACT_COPY      = 3'd2;
    localparam logic [2:0] ACT_INVAL     = 3'd3;
    localparam logic [2:0] ACT_DONE      = 3'd4;

    localparam int SKIP_W = 8;

    typedef struct packed {
        logic [2:0]        phase;
        logic [31:0]       mem_cursor;
        logic [31:0]       file_cursor;
        logic [30:0]       request_size;
        logic [31:0]       mem_first_aligned;
        logic [31:0]       mem_end;
        logic [31:0]       mem_end_aligned;
        logic [SKIP_W-1:0] head_skip;
        logic [30:0]       kept_sum;
    } state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] mem_addr;
        logic [31:0] file_pos;
        logic [30:0] length;
        logic [4:0]  bounce_pos;
        logic [30:0] kept_total;
        logic        last;
    } res_t;

endpackage

// ----- design/urs_step.sv -----
// Next-state and result logic for one transaction of the unaligned read splitter.
// Depends on urs_pkg for the state and result records.
module urs_step #(
    parameter int CHUNK_BYTES = 16384,
    parameter int ALIGN_BYTES = 32
) (
    input  logic            kind,
    input  logic [31:0]     dest_addr,
    input  logic [31:0]     src_offset,
    input  logic [30:0]     byte_count,
    input  urs_pkg::state_t cur,
    output urs_pkg::state_t nxt,
    output urs_pkg::res_t   res0,
    output urs_pkg::res_t   res1,
    output logic [1:0]      num_res
);
    import urs_pkg::*;

    localparam logic [31:0] AMASK   = 32'(ALIGN_BYTES - 1);
    localparam logic [31:0] ABYTES  = 32'(ALIGN_BYTES);
    localparam logic [32:0] CHUNK33 = 33'(CHUNK_BYTES);

    function automatic res_t blank();
        res_t r;
        r = '0;
        return r;
    endfunction

    // issue the next device read after the head or an aligned start, or report done
    function automatic void issue_next(inout state_t s, output res_t r);
        logic [31:0] rem;
        logic [31:0] dlen;
        logic [32:0] len33;
        rem  = s.mem_end - s.mem_cursor;
        dlen = s.mem_end_aligned - s.mem_cursor;
        len33 = ({1'b0, rem} + {1'b0, AMASK}) & ~{1'b0, AMASK};
        if (len33 > CHUNK33) begin
            len33 = CHUNK33;
        end
        r = blank();
        r.last = 1'b1;
        if (s.mem_cursor == s.mem_first_aligned && dlen != 32'd0) begin
            s.phase    = PH_DIRECT;
            r.action   = ACT_RD_DIRECT;
            r.mem_addr = s.mem_cursor;
            r.file_pos = s.file_cursor;
            r.length   = dlen[30:0];
        end else if (rem != 32'd0) begin
            s.phase    = PH_TAIL;
            r.action   = ACT_RD_BOUNCE;
            r.file_pos = s.file_cursor;
            r.length   = len33[30:0];
        end else begin
            s.phase      = PH_IDLE;
            r.action     = ACT_DONE;
            r.kept_total = s.kept_sum;
        end
    endfunction

    always_comb begin
        state_t      s;
        res_t        r0;
        res_t        r1;
        logic [1:0]  n;
        logic [31:0] keep;
        logic [31:0] skip32;
        logic [31:0] small_len;
        logic [31:0] tail_rem;
        s    = cur;
        r0   = blank();
        r1   = blank();
        n    = 2'd0;
        keep = 32'd0;
        skip32    = {{(32-SKIP_W){1'b0}}, cur.head_skip};
        small_len = 32'd0;
        tail_rem  = cur.mem_end - cur.mem_cursor;
        if (!kind) begin
            s.request_size      = byte_count;
            s.kept_sum          = '0;
            s.mem_cursor        = dest_addr;
            s.file_cursor       = src_offset;
            s.mem_first_aligned = (dest_addr + AMASK) & ~AMASK;
            s.mem_end           = dest_addr + {1'b0, byte_count};
            s.mem_end_aligned   = (dest_addr + {1'b0, byte_count}) & ~AMASK;
            s.head_skip         = SKIP_W'(src_offset & AMASK);
            skip32    = src_offset & AMASK;
            small_len = (skip32 + {1'b0, byte_count} + AMASK) & ~AMASK;
            n = 2'd1;
            r0.last = 1'b1;
            if (byte_count == 31'd0) begin
                s.phase    = PH_IDLE;
                r0.action  = ACT_DONE;
            end else if ({1'b0, byte_count} < ABYTES) begin
                s.phase     = PH_SMALL;
                r0.action   = ACT_RD_BOUNCE;
                r0.file_pos = src_offset & ~AMASK;
                r0.length   = small_len[30:0];
            end else if (skip32 != 32'd0) begin
                s.phase     = PH_HEAD;
                r0.action   = ACT_RD_BOUNCE;
                r0.file_pos = src_offset & ~AMASK;
                r0.length   = ABYTES[30:0];
            end else begin
                issue_next(s, r0);
            end
        end else begin
            unique case (cur.phase)
                PH_SMALL: begin
                    r0.action     = ACT_COPY;
                    r0.mem_addr   = cur.mem_cursor;
                    r0.length     = cur.request_size;
                    r0.bounce_pos = cur.head_skip[4:0];
                    s.kept_sum    = cur.kept_sum + cur.request_size;
                    s.phase       = PH_IDLE;
                    r1.action     = ACT_DONE;
                    r1.kept_total = s.kept_sum;
                    r1.last       = 1'b1;
                    n = 2'd2;
                end
                PH_HEAD, PH_DIRECT, PH_TAIL: begin
                    r0.mem_addr = cur.mem_cursor;
                    if (cur.phase == PH_HEAD) begin
                        keep          = ABYTES - skip32;
                        r0.action     = ACT_COPY;
                        r0.bounce_pos = cur.head_skip[4:0];
                    end else if (cur.phase == PH_DIRECT) begin
                        keep      = cur.mem_end_aligned - cur.mem_cursor;
                        r0.action = ACT_INVAL;
                    end else begin
                        keep = (tail_rem > CHUNK33[31:0]) ? CHUNK33[31:0] : tail_rem;
                        r0.action = ACT_COPY;
                    end
                    r0.length     = keep[30:0];
                    s.mem_cursor  = cur.mem_cursor + keep;
                    s.file_cursor = cur.file_cursor + keep;
                    s.kept_sum    = cur.kept_sum + keep[30:0];
                    issue_next(s, r1);
                    n = 2'd2;
                end
                default: begin
                    n = 2'd0;
                end
            endcase
        end
        nxt     = s;
        res0    = r0;
        res1    = r1;
        num_res = n;
    end

endmodule

// ----- design/unaligned_read_splitter.sv -----
// Top level of the unaligned read splitter: state registers and a result queue.
// Depends on urs_pkg and urs_step.
//
// Usage: the slave channel takes one transaction per request or device event.
// s_tuser is the kind (0 start a read, 1 previous device read completed);
// s_tdata carries dest_addr, src_offset and byte_count. Each accepted
// transaction produces zero, one or two result transactions on the master
// channel: m_tuser is the action, m_tdata the command fields, and m_tlast
// marks the final result of that input.
// Results are registered in the queue before they reach the master channel.
// Results leave one per cycle while m_tready is high, so single-result inputs
// are accepted one per cycle and inputs with two results more slowly.
// The rate is set by the single master port draining the four-entry queue.
// Reset (aresetn low, synchronous) empties the queue and returns to idle.
// When the receiver stalls, results hold in the queue; s_tready drops once
// fewer than two entries are free.
module unaligned_read_splitter #(
    parameter int CHUNK_BYTES = 16384,
    parameter int ALIGN_BYTES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // dest_addr[31:0], src_offset[63:32], byte_count[94:64]
    input  logic [0:0]   s_tuser,   // kind[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // mem_addr[31:0], file_pos[63:32], length[94:64],
                                    // bounce_pos[99:95], kept_total[130:100]
    output logic [2:0]   m_tuser,   // action[2:0]
    output logic         m_tlast    // last
);
    import urs_pkg::*;

    localparam int DEPTH = 4;

    state_t     st_reg;
    state_t     st_next;
    res_t       res0;
    res_t       res1;
    logic [1:0] num_res;
    res_t       q_reg [DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       s_acc;
    logic       m_acc;
    logic [1:0] push;
    res_t       head;

    urs_step #(
        .CHUNK_BYTES(CHUNK_BYTES),
        .ALIGN_BYTES(ALIGN_BYTES)
    ) u_step (
        .kind       (s_tuser[0]),
        .dest_addr  (s_tdata[31:0]),
        .src_offset (s_tdata[63:32]),
        .byte_count (s_tdata[94:64]),
        .cur        (st_reg),
        .nxt        (st_next),
        .res0       (res0),
        .res1       (res1),
        .num_res    (num_res)
    );

    assign s_tready   = (count_reg <= 3'd2);
    assign s_acc      = s_tvalid && s_tready;
    assign m_acc      = m_tvalid && m_tready;
    assign push       = s_acc ? num_res : 2'd0;
    assign count_next = count_reg + {1'b0, push} - {2'b0, m_acc};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_acc) begin
                st_reg <= st_next;
            end
            wr_ptr_reg <= wr_ptr_reg + push;
            if (m_acc) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push != 2'd0) begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (push == 2'd2) begin
            q_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tuser  = head.action;
    assign m_tlast  = head.last;
    assign m_tdata  = {5'b0, head.kept_total, head.bounce_pos, head.length,
                       head.file_pos, head.mem_addr};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'(DEPTH))
        else $error("result queue overflow");

    a_idle_event: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser[0] && st_reg.phase == PH_IDLE |=> count_reg <= $past(count_reg))
        else $error("completion while idle produced a result");

    a_zero_done: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && !s_tuser[0] && s_tdata[94:64] == 31'd0 |=> st_reg.phase == PH_IDLE)
        else $error("zero byte start did not return to idle");
`endif

endmodule

// ----- test/tb_unaligned_read_splitter.sv -----
// Self-checking testbench for unaligned_read_splitter: walks a directed table, then random
// read requests and completion events, each command checked against an in-bench predictor.
// Depends on urs_pkg and the unaligned_read_splitter RTL only.
module tb_unaligned_read_splitter;
    import urs_pkg::*;

    localparam logic        KIND_START    = 1'b0;
    localparam logic        KIND_COMPLETE = 1'b1;
    localparam logic [31:0] CHUNK         = 32'd16384;
    localparam logic [31:0] ALIGN_MASK    = 32'd31;
    localparam int          RANDOM_ITEMS  = 1650;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          NUM_ROWS      = 24;

    localparam res_t NO_CMD    = '0;
    localparam res_t DONE_ZERO = '{action: ACT_DONE, mem_addr: 32'd0, file_pos: 32'd0,
                                   length: 31'd0, bounce_pos: 5'd0, kept_total: 31'd0,
                                   last: 1'b1};

    typedef struct {
        logic        kind;
        logic [31:0] dest;
        logic [31:0] src;
        logic [30:0] count;
        int          n_typed;
        res_t        typed;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    bit steady = 1'b0;
    int errors = 0;
    int cycles = 0;
    int n_results = 0;

    res_t cmd_q[$];

    logic [2:0]  rd_phase = PH_IDLE;
    logic [31:0] mem_cur = '0;
    logic [31:0] file_cur = '0;
    logic [30:0] req_size = '0;
    logic [31:0] mem_first_al = '0;
    logic [31:0] mem_stop = '0;
    logic [31:0] mem_stop_al = '0;
    logic [4:0]  skip_bytes = '0;
    logic [5:0]  keep_bytes = '0;
    logic [30:0] kept_bytes = '0;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,          0, NO_CMD},
        '{KIND_START,    32'h0000_0000, 32'h0000_0000, 31'd0,          1, DONE_ZERO},
        '{KIND_START,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd0,          1, DONE_ZERO},
        '{KIND_START,    32'h0000_0003, 32'h0000_0005, 31'd10,        -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_START,    32'h0000_0100, 32'h0000_0040, 31'd4096,      -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_START,    32'h0000_1007, 32'h0000_2007, 31'd200,       -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_START,    32'h0000_0001, 32'h0000_0000, 31'd40000,     -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_START,    32'h0000_0000, 32'h0000_0003, 31'h7FFF_FFFF, -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_START,    32'hFFFF_FFF0, 32'h0000_0000, 31'd64,        -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_START,    32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD},
        '{KIND_START,    32'hFFFF_FFFF, 32'h0000_001F, 31'd31,        -1, NO_CMD},
        '{KIND_COMPLETE, 32'h0000_0000, 32'h0000_0000, 31'd0,         -1, NO_CMD}
    };

    unaligned_read_splitter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void push_cmd(logic [2:0] act, logic [31:0] mem, logic [31:0] fpos,
                                     logic [30:0] len, logic [4:0] bpos, logic [30:0] kept,
                                     logic last);
        res_t r;
        r.action     = act;
        r.mem_addr   = mem;
        r.file_pos   = fpos;
        r.length     = len;
        r.bounce_pos = bpos;
        r.kept_total = kept;
        r.last       = last;
        cmd_q.push_back(r);
    endfunction

    function automatic void finish_read();
        rd_phase = PH_IDLE;
        push_cmd(ACT_DONE, 32'd0, 32'd0, 31'd0, 5'd0, kept_bytes, 1'b1);
    endfunction

    function automatic void take_bytes(logic [31:0] n);
        mem_cur    = mem_cur + n;
        file_cur   = file_cur + n;
        kept_bytes = kept_bytes + n[30:0];
    endfunction

    // Direct read once memory is aligned, else a bounce chunk, else done.
    function automatic void plan_next_read();
        logic [31:0] rem;
        logic [31:0] direct_len;
        logic [63:0] len;
        rem        = mem_stop - mem_cur;
        direct_len = mem_stop_al - mem_cur;
        if (mem_cur == mem_first_al && direct_len != 32'd0) begin
            rd_phase = PH_DIRECT;
            push_cmd(ACT_RD_DIRECT, mem_cur, file_cur, direct_len[30:0], 5'd0, 31'd0, 1'b1);
        end else if (rem != 32'd0) begin
            len = ({32'd0, rem} + 64'd31) & ~64'd31;
            if (len > {32'd0, CHUNK}) begin
                len = {32'd0, CHUNK};
            end
            rd_phase = PH_TAIL;
            push_cmd(ACT_RD_BOUNCE, 32'd0, file_cur, len[30:0], 5'd0, 31'd0, 1'b1);
        end else begin
            finish_read();
        end
    endfunction

    function automatic void split_read(logic kind, logic [31:0] dest, logic [31:0] src,
                                       logic [30:0] count);
        logic [31:0] keep;
        if (kind == KIND_START) begin
            req_size     = count;
            kept_bytes   = '0;
            mem_cur      = dest;
            file_cur     = src;
            mem_first_al = (dest + ALIGN_MASK) & ~ALIGN_MASK;
            mem_stop     = dest + {1'b0, count};
            mem_stop_al  = mem_stop & ~ALIGN_MASK;
            skip_bytes   = src[4:0];
            keep_bytes   = 6'd32 - {1'b0, skip_bytes};
            if (count == 31'd0) begin
                finish_read();
            end else if (count < 31'd32) begin
                keep = ({27'd0, skip_bytes} + {1'b0, count} + ALIGN_MASK) & ~ALIGN_MASK;
                rd_phase = PH_SMALL;
                push_cmd(ACT_RD_BOUNCE, 32'd0, src & ~ALIGN_MASK, keep[30:0], 5'd0, 31'd0, 1'b1);
            end else if (skip_bytes != 5'd0) begin
                rd_phase = PH_HEAD;
                push_cmd(ACT_RD_BOUNCE, 32'd0, src & ~ALIGN_MASK, 31'd32, 5'd0, 31'd0, 1'b1);
            end else begin
                plan_next_read();
            end
        end else begin
            case (rd_phase)
                PH_SMALL: begin
                    push_cmd(ACT_COPY, mem_cur, 32'd0, req_size, skip_bytes, 31'd0, 1'b0);
                    kept_bytes = kept_bytes + req_size;
                    finish_read();
                end
                PH_HEAD: begin
                    keep = {26'd0, keep_bytes};
                    push_cmd(ACT_COPY, mem_cur, 32'd0, keep[30:0], skip_bytes, 31'd0, 1'b0);
                    take_bytes(keep);
                    plan_next_read();
                end
                PH_DIRECT: begin
                    keep = mem_stop_al - mem_cur;
                    push_cmd(ACT_INVAL, mem_cur, 32'd0, keep[30:0], 5'd0, 31'd0, 1'b0);
                    take_bytes(keep);
                    plan_next_read();
                end
                PH_TAIL: begin
                    keep = mem_stop - mem_cur;
                    if (keep > CHUNK) begin
                        keep = CHUNK;
                    end
                    push_cmd(ACT_COPY, mem_cur, 32'd0, keep[30:0], 5'd0, 31'd0, 1'b0);
                    take_bytes(keep);
                    plan_next_read();
                end
                default: begin
                end
            endcase
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("[%0d] result %0d %s: got %h, expected %h", cycles, n_results, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    // Present one transaction, hold it until accepted, then predict; returns the count pushed.
    task automatic send_item(input logic kind, input logic [31:0] dest, input logic [31:0] src,
                             input logic [30:0] count, output int pushed);
        int base;
        if (!steady) begin
            while ($urandom_range(0, 99) < 8) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, count, src, dest};
        do @(posedge aclk); while (!s_tready);
        base = cmd_q.size();
        split_read(kind, dest, src, count);
        pushed = cmd_q.size() - base;
    endtask

    task automatic drain_commands();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (cmd_q.size() != 0);
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (cmd_q.size() == 0) begin
                report_mismatch("unexpected, action", {29'd0, m_tuser}, 32'd0);
            end else begin
                want = cmd_q.pop_front();
                check_field("action", {29'd0, m_tuser}, {29'd0, want.action});
                check_field("mem_addr", m_tdata[31:0], want.mem_addr);
                check_field("file_pos", m_tdata[63:32], want.file_pos);
                check_field("length", {1'b0, m_tdata[94:64]}, {1'b0, want.length});
                check_field("bounce_pos", {27'd0, m_tdata[99:95]}, {27'd0, want.bounce_pos});
                check_field("kept_total", {1'b0, m_tdata[130:100]}, {1'b0, want.kept_total});
                check_field("last", {31'd0, m_tlast}, {31'd0, want.last});
            end
        end
    end

    initial begin
        int pushed;
        int counted;
        int steps;
        int cap;
        int sel;
        logic        kind;
        logic [31:0] dest;
        logic [31:0] src;
        logic [30:0] count;
        bit          paused;

        counted = 0;
        paused  = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            send_item(directed_rows[i].kind, directed_rows[i].dest, directed_rows[i].src,
                      directed_rows[i].count, pushed);
            if (directed_rows[i].n_typed >= 0) begin
                repeat (pushed) void'(cmd_q.pop_back());
                if (directed_rows[i].n_typed > 0) begin
                    cmd_q.push_back(directed_rows[i].typed);
                end
            end
        end
        drain_commands();

        while (counted < RANDOM_ITEMS) begin
            steady = (counted >= 700 && counted < 1000);
            if (!paused && counted >= 1200) begin
                paused = 1'b1;
                drain_commands();
            end
            if ($urandom_range(0, 99) < 6) begin
                // stray event: ignored when idle, completes a step otherwise
                if (rd_phase != PH_IDLE) begin
                    counted++;
                end
                send_item(KIND_COMPLETE, $urandom(), $urandom(), 31'($urandom()), pushed);
            end else begin
                dest = $urandom();
                src  = $urandom();
                sel  = $urandom_range(0, 3);
                if (sel == 0) begin
                    src[4:0] = dest[4:0];
                end else if (sel == 1) begin
                    dest[4:0] = 5'd0;
                    src[4:0]  = 5'd0;
                end else if (sel == 2) begin
                    src[4:0] = 5'd0;
                end
                sel = $urandom_range(0, 9);
                if (sel < 4) begin
                    count = 31'($urandom_range(0, 63));
                end else if (sel < 7) begin
                    count = 31'($urandom_range(0, 4095));
                end else if (sel < 9) begin
                    count = 31'($urandom_range(0, 65535));
                end else begin
                    count = 31'($urandom());
                end
                kind = KIND_START;
                counted++;
                send_item(kind, dest, src, count, pushed);
                cap   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 12;
                steps = 0;
                while (rd_phase != PH_IDLE && steps < cap) begin
                    counted++;
                    steps++;
                    send_item(KIND_COMPLETE, $urandom(), $urandom(), 31'($urandom()), pushed);
                end
            end
        end
        steady = 1'b0;

        drain_commands();
        repeat (16) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
